// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ULEBRD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ULEBRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ulebrd_pkg.sv =====
// Types, constants and codes shared by the LEB128 run decoder.
package ulebrd_pkg;

	localparam int unsigned COUNT_BITS = 32;
	localparam logic [31:0] COUNT_MASK = (COUNT_BITS >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << COUNT_BITS) - 64'd1);

	localparam int unsigned ACCUM_W = 64;
	localparam logic [6:0] SHIFT_STEP = 7'd7;
	localparam logic [6:0] SHIFT_CAP = 7'd70;

	// Command codes
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_BYTE = 2'd1;
	localparam logic [1:0] CMD_END = 2'd2;

	// Pipeline transaction kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_RUN = 2'd1;
	localparam logic [1:0] KIND_END = 2'd2;

	// Division by 11: v = vh * 2^18 + vl, 2^18 = 11 * 23831 + 3
	localparam logic [3:0] DIVISOR = 4'd11;
	localparam logic [14:0] Q_HI = 15'd23831;
	localparam logic [20:0] RECIP_T = 21'd1525202;
	localparam int unsigned RECIP_T_SHIFT = 24;
	localparam logic [10:0] RECIP_M = 11'd1490;
	localparam int unsigned RECIP_M_SHIFT = 14;

	localparam logic [7:0] GLYPH_SPACE = 8'h20;
	localparam logic [7:0] GLYPH_BEFORE_ZERO = 8'h2F;

	localparam logic [31:0] BUCKET_0_MAX = 32'd11;
	localparam logic [31:0] BUCKET_1_MAX = 32'd128;
	localparam logic [31:0] BUCKET_2_MAX = 32'd1489;
	localparam logic [31:0] BUCKET_3_MAX = 32'd16384;

	typedef struct packed {
		logic [1:0] cmd;
		logic [31:0] symbol_total;
		logic [7:0] code_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic [31:0] run_length;
		logic [2:0] size_bucket;
		logic is_padding;
		logic last;
	} run_t;

	// Completed value, split for the divider
	typedef struct packed {
		logic [1:0] kind;
		logic [31:0] total;
		logic big;
		logic [17:0] vh;
		logic [19:0] t;
		logic [12:0] csum;
	} pre_t;

	// Partial quotient and remainder
	typedef struct packed {
		logic [1:0] kind;
		logic [31:0] total;
		logic big;
		logic [32:0] p1;
		logic [16:0] p2;
		logic [3:0] rem;
	} mid_t;

endpackage

// ===== hdl/uleb_indicator_run_decoder.sv =====
// Top level of the LEB128 indicator run decoder.
// Input channel item (item_valid/item_stall) carries start, byte and end
// transactions; output channel run (run_valid/run_stall) carries one run per
// completed LEB128 value and one space padding run on an end with symbols
// still missing. Start, continuation bytes and ignored bytes give no run.
// Throughput: one transaction per cycle while run_stall does not back up the
// pipeline, set by the LEB128 accumulator loop and the remaining-count clip.
// A run passes from its closing byte or end transaction through the input
// register, the accumulator register, the divide-by-11 stage register and,
// after the clip, the result register.
// Reset clears all valids, the accumulator and the remaining count; before
// any start the stream counts as full and bytes are dropped.
// When run_stall is held the result register keeps its run; the stages
// behind it keep filling and item_stall rises once all three are occupied.
module uleb_indicator_run_decoder (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input ulebrd_pkg::item_t item,
	output logic run_valid,
	input logic run_stall,
	output ulebrd_pkg::run_t run
);

	logic s2_valid;
	logic s2_ready;
	ulebrd_pkg::pre_t s2;
	logic s3_valid;
	logic s3_ready;
	ulebrd_pkg::mid_t s3;

	ulebrd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.s2_valid(s2_valid),
		.s2_ready(s2_ready),
		.s2(s2)
	);

	ulebrd_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.s2_valid(s2_valid),
		.s2_ready(s2_ready),
		.s2(s2),
		.s3_valid(s3_valid),
		.s3_ready(s3_ready),
		.s3(s3)
	);

	ulebrd_clip u_clip (
		.clk(clk),
		.arst_n(arst_n),
		.s3_valid(s3_valid),
		.s3_ready(s3_ready),
		.s3(s3),
		.run_valid(run_valid),
		.run_stall(run_stall),
		.run(run)
	);

endmodule

// ===== hdl/ulebrd_front.sv =====
// Input register and LEB128 accumulator.
`include "assert_macros.svh"

module ulebrd_front (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input ulebrd_pkg::item_t item,
	output logic s2_valid,
	input logic s2_ready,
	output ulebrd_pkg::pre_t s2
);

	logic valid_s1;
	ulebrd_pkg::item_t item_s1;
	logic valid_s2;
	ulebrd_pkg::pre_t pre_s2;
	logic ready_s2;
	logic take_s1;
	logic accept;
	logic [63:0] accum_q;
	logic [63:0] accum_n;
	logic [63:0] contrib;
	logic [63:0] merged;
	logic [6:0] shift_q;
	logic [6:0] shift_n;
	logic [6:0] shift_inc;
	logic [12:0] csum;
	logic emit;
	ulebrd_pkg::pre_t pre_n;

	assign ready_s2 = !valid_s2 || s2_ready;
	assign take_s1 = valid_s1 && ready_s2;
	assign item_stall = valid_s1 && !ready_s2;
	assign accept = item_valid && !item_stall;

	always_comb begin
		contrib = (shift_q < 7'(ulebrd_pkg::ACCUM_W)) ?
			(64'(item_s1.code_byte[6:0]) << shift_q[5:0]) : '0;
		merged = accum_q | contrib;
		shift_inc = shift_q + ulebrd_pkg::SHIFT_STEP;
		// 2^10 = 1 mod 11: sum of 10-bit chunks keeps the remainder
		csum = 13'(merged[9:0]) + 13'(merged[19:10]) + 13'(merged[29:20])
			+ 13'(merged[39:30]) + 13'(merged[49:40]) + 13'(merged[59:50])
			+ 13'(merged[63:60]);

		accum_n = accum_q;
		shift_n = shift_q;
		emit = 1'b0;
		pre_n.kind = ulebrd_pkg::KIND_RUN;
		pre_n.total = item_s1.symbol_total & ulebrd_pkg::COUNT_MASK;
		pre_n.big = |merged[63:36];
		pre_n.vh = merged[35:18];
		pre_n.t = 20'({merged[35:18], 1'b0}) + 20'(merged[35:18]) + 20'(merged[17:0]);
		pre_n.csum = csum;

		unique case (item_s1.cmd)
			ulebrd_pkg::CMD_START: begin
				accum_n = '0;
				shift_n = '0;
				emit = 1'b1;
				pre_n.kind = ulebrd_pkg::KIND_START;
			end
			ulebrd_pkg::CMD_BYTE: begin
				accum_n = merged;
				shift_n = (shift_inc > ulebrd_pkg::SHIFT_CAP) ? ulebrd_pkg::SHIFT_CAP : shift_inc;
				if (!item_s1.code_byte[7]) begin
					accum_n = '0;
					shift_n = '0;
					emit = 1'b1;
				end
			end
			ulebrd_pkg::CMD_END: begin
				accum_n = '0;
				shift_n = '0;
				emit = 1'b1;
				pre_n.kind = ulebrd_pkg::KIND_END;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			accum_q <= '0;
			shift_q <= '0;
		end else begin
			if (!item_stall)
				valid_s1 <= item_valid;
			if (take_s1) begin
				accum_q <= accum_n;
				shift_q <= shift_n;
			end
			if (ready_s2)
				valid_s2 <= take_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= item;
		if (take_s1 && emit)
			pre_s2 <= pre_n;
	end

	assign s2_valid = valid_s2;
	assign s2 = pre_s2;

	`ULEBRD_ASSERT_NEXT(a_shift_clear, clk, arst_n, take_s1 && emit, shift_q == '0,
		"accumulator shift not cleared after a forwarded transaction")

endmodule

// ===== hdl/ulebrd_div.sv =====
// Division by 11 stage: partial quotients and remainder.
`include "assert_macros.svh"

module ulebrd_div (
	input logic clk,
	input logic arst_n,
	input logic s2_valid,
	output logic s2_ready,
	input ulebrd_pkg::pre_t s2,
	output logic s3_valid,
	input logic s3_ready,
	output ulebrd_pkg::mid_t s3
);

	logic valid_s3;
	ulebrd_pkg::mid_t mid_s3;
	ulebrd_pkg::mid_t mid_n;
	logic take;
	logic [40:0] tm;
	logic [10:0] fold;
	logic [21:0] mm;
	logic [7:0] qm;

	assign s2_ready = !valid_s3 || s3_ready;
	assign take = s2_valid && s2_ready;

	always_comb begin
		tm = 41'(s2.t) * 41'(ulebrd_pkg::RECIP_T);
		fold = 11'(s2.csum[12:10]) + 11'(s2.csum[9:0]);
		mm = 22'(fold) * 22'(ulebrd_pkg::RECIP_M);
		qm = mm[ulebrd_pkg::RECIP_M_SHIFT +: 8];

		mid_n.kind = s2.kind;
		mid_n.total = s2.total;
		mid_n.big = s2.big;
		mid_n.p1 = 33'(s2.vh) * 33'(ulebrd_pkg::Q_HI);
		mid_n.p2 = tm[ulebrd_pkg::RECIP_T_SHIFT +: 17];
		mid_n.rem = 4'(fold - 11'(11'(qm) * 11'(ulebrd_pkg::DIVISOR)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (s2_ready)
			valid_s3 <= s2_valid;
	end

	always_ff @(posedge clk) begin
		if (take)
			mid_s3 <= mid_n;
	end

	assign s3_valid = valid_s3;
	assign s3 = mid_s3;

	`ULEBRD_ASSERT_NOW(a_rem_range, clk, arst_n,
		valid_s3 && mid_s3.kind == ulebrd_pkg::KIND_RUN, mid_s3.rem < ulebrd_pkg::DIVISOR,
		"remainder mod 11 out of range")

endmodule

// ===== hdl/ulebrd_clip.sv =====
// Run clipping against the stream total, and the result register.
`include "assert_macros.svh"

module ulebrd_clip (
	input logic clk,
	input logic arst_n,
	input logic s3_valid,
	output logic s3_ready,
	input ulebrd_pkg::mid_t s3,
	output logic run_valid,
	input logic run_stall,
	output ulebrd_pkg::run_t run
);

	logic run_valid_q;
	ulebrd_pkg::run_t run_q;
	ulebrd_pkg::run_t res;
	logic [31:0] room_q;
	logic [31:0] room_n;
	logic full_q;
	logic full_n;
	logic take;
	logic live;
	logic emit;
	logic clip;
	logic [33:0] cnt;
	logic [31:0] len;

	function automatic logic [7:0] glyph(input logic [3:0] r);
		logic [7:0] g;
		if (r == '0 || r >= ulebrd_pkg::DIVISOR)
			g = ulebrd_pkg::GLYPH_SPACE;
		else
			g = ulebrd_pkg::GLYPH_BEFORE_ZERO + 8'(r);
		return g;
	endfunction

	function automatic logic [2:0] size_class(input logic [31:0] n);
		logic [2:0] c;
		if (n <= ulebrd_pkg::BUCKET_0_MAX)
			c = 3'd0;
		else if (n <= ulebrd_pkg::BUCKET_1_MAX)
			c = 3'd1;
		else if (n <= ulebrd_pkg::BUCKET_2_MAX)
			c = 3'd2;
		else if (n <= ulebrd_pkg::BUCKET_3_MAX)
			c = 3'd3;
		else
			c = 3'd4;
		return c;
	endfunction

	assign s3_ready = !run_valid_q || !run_stall;
	assign take = s3_valid && s3_ready;

	always_comb begin
		cnt = 34'(s3.p1) + 34'(s3.p2) + 34'd1;
		clip = s3.big || (cnt > 34'(room_q));
		len = clip ? room_q : cnt[31:0];
		live = !full_q && (room_q != '0);

		room_n = room_q;
		full_n = full_q;
		emit = 1'b0;
		res.symbol = glyph(s3.rem);
		res.run_length = len;
		res.is_padding = 1'b0;
		res.last = 1'b0;

		unique case (s3.kind)
			ulebrd_pkg::KIND_START: begin
				room_n = s3.total;
				full_n = (s3.total == '0);
			end
			ulebrd_pkg::KIND_RUN: begin
				if (live) begin
					room_n = room_q - len;
					full_n = (room_n == '0);
					res.last = (room_n == '0);
					emit = 1'b1;
				end
			end
			ulebrd_pkg::KIND_END: begin
				if (live) begin
					res.symbol = ulebrd_pkg::GLYPH_SPACE;
					res.run_length = room_q;
					res.is_padding = 1'b1;
					res.last = 1'b1;
					room_n = '0;
					emit = 1'b1;
				end
				full_n = 1'b1;
			end
			default: begin
			end
		endcase

		res.size_bucket = size_class(res.run_length);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
			room_q <= '0;
			full_q <= 1'b0;
		end else begin
			if (take) begin
				room_q <= room_n;
				full_q <= full_n;
			end
			if (s3_ready)
				run_valid_q <= take && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit)
			run_q <= res;
	end

	assign run_valid = run_valid_q;
	assign run = run_q;

	`ULEBRD_ASSERT_NEXT(a_room_mono, clk, arst_n,
		!(take && s3.kind == ulebrd_pkg::KIND_START), room_q <= $past(room_q),
		"remaining count grew without a start transaction")
	`ULEBRD_ASSERT_NOW(a_last_full, clk, arst_n, run_valid_q && run_q.last,
		full_q && room_q == '0, "final run shown while stream still open")
	`ULEBRD_ASSERT_NOW(a_len_nonzero, clk, arst_n, run_valid_q, run_q.run_length != '0,
		"empty run emitted")

endmodule

// ===== test/uleb_indicator_run_decoder_test.sv =====
// Self-checking testbench for the LEB128 indicator run decoder.

class run_scoreboard;
	ulebrd_pkg::run_t expected_runs[$];
	logic [63:0] accum;
	logic [6:0] shift;
	logic [31:0] decoded;
	logic [31:0] total;
	bit full;
	int mismatches;

	function new();
		accum = '0;
		shift = '0;
		decoded = '0;
		total = '0;
		full = 1'b0;
		mismatches = 0;
	endfunction

	function logic [2:0] bucket_of(logic [31:0] n);
		if (n <= ulebrd_pkg::BUCKET_0_MAX) return 3'd0;
		if (n <= ulebrd_pkg::BUCKET_1_MAX) return 3'd1;
		if (n <= ulebrd_pkg::BUCKET_2_MAX) return 3'd2;
		if (n <= ulebrd_pkg::BUCKET_3_MAX) return 3'd3;
		return 3'd4;
	endfunction

	function int pending();
		return expected_runs.size();
	endfunction

	function void note_item(ulebrd_pkg::item_t it);
		logic [63:0] v;
		logic [63:0] cnt;
		logic [63:0] room;
		logic [3:0] rem;
		ulebrd_pkg::run_t r;
		case (it.cmd)
			ulebrd_pkg::CMD_START: begin
				accum = '0;
				shift = '0;
				decoded = '0;
				total = it.symbol_total & ulebrd_pkg::COUNT_MASK;
				full = (total == 32'd0);
			end
			ulebrd_pkg::CMD_BYTE: begin
				if (!(full || decoded >= total)) begin
					if (shift < 7'd64)
						accum = accum | (64'(it.code_byte[6:0]) << shift);
					shift = (shift > ulebrd_pkg::SHIFT_CAP - ulebrd_pkg::SHIFT_STEP) ?
						ulebrd_pkg::SHIFT_CAP : shift + ulebrd_pkg::SHIFT_STEP;
					if (!it.code_byte[7]) begin
						v = accum;
						accum = '0;
						shift = '0;
						cnt = v / 64'd11 + 64'd1;
						room = 64'(total) - 64'(decoded);
						if (cnt > room)
							cnt = room;
						decoded = decoded + cnt[31:0];
						rem = 4'(v % 64'd11);
						r.symbol = (rem == 4'd0) ? ulebrd_pkg::GLYPH_SPACE :
							ulebrd_pkg::GLYPH_BEFORE_ZERO + 8'(rem);
						r.run_length = cnt[31:0];
						r.size_bucket = bucket_of(cnt[31:0]);
						r.is_padding = 1'b0;
						r.last = (decoded >= total);
						if (r.last)
							full = 1'b1;
						expected_runs.push_back(r);
					end
				end
			end
			ulebrd_pkg::CMD_END: begin
				accum = '0;
				shift = '0;
				if (!full && decoded < total) begin
					r.symbol = ulebrd_pkg::GLYPH_SPACE;
					r.run_length = total - decoded;
					r.size_bucket = bucket_of(total - decoded);
					r.is_padding = 1'b1;
					r.last = 1'b1;
					expected_runs.push_back(r);
					decoded = total;
				end
				full = 1'b1;
			end
			default: ;
		endcase
	endfunction

	function void report(string what, ulebrd_pkg::run_t e, ulebrd_pkg::run_t g);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s: exp sym %h len %0d bkt %0d pad %b last %b",
				what, e.symbol, e.run_length, e.size_bucket, e.is_padding, e.last);
			$display("%s: got sym %h len %0d bkt %0d pad %b last %b",
				what, g.symbol, g.run_length, g.size_bucket, g.is_padding, g.last);
		end
	endfunction

	function void check_run(ulebrd_pkg::run_t got);
		ulebrd_pkg::run_t exp_run;
		if (expected_runs.size() == 0) begin
			report("unexpected run", '0, got);
			return;
		end
		exp_run = expected_runs.pop_front();
		if (got.symbol !== exp_run.symbol || got.run_length !== exp_run.run_length ||
				got.size_bucket !== exp_run.size_bucket ||
				got.is_padding !== exp_run.is_padding || got.last !== exp_run.last)
			report("run mismatch", exp_run, got);
	endfunction
endclass

module uleb_indicator_run_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int USEFUL_ITEMS = 1500;
	localparam int SETTLE_CYCLES = 8;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	ulebrd_pkg::item_t item;
	logic run_valid;
	logic run_stall;
	ulebrd_pkg::run_t run;

	run_scoreboard sb;
	int cycles = 0;
	int useful = 0;
	int hold_req = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	uleb_indicator_run_decoder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.run_valid(run_valid),
		.run_stall(run_stall),
		.run(run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				sb.note_item(item);
			if (run_valid && !run_stall)
				sb.check_run(run);
		end
	end

	// run receiver: random back-pressure, plus long holds on request
	initial begin
		int n;
		run_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			n = rx_calm ? 0 : $urandom_range(0, 11);
			n += hold_req;
			hold_req = 0;
			if (n > 0) begin
				run_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			run_stall <= 1'b0;
			do @(posedge clk); while (!run_valid);
		end
	end

	function automatic ulebrd_pkg::item_t mk(logic [1:0] c, logic [31:0] tot, logic [7:0] b);
		ulebrd_pkg::item_t it;
		it.cmd = c;
		it.symbol_total = tot;
		it.code_byte = b;
		return it;
	endfunction

	function automatic ulebrd_pkg::item_t mk_byte(logic [7:0] b);
		return mk(ulebrd_pkg::CMD_BYTE, $urandom, b);
	endfunction

	task automatic send_item(input ulebrd_pkg::item_t x);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= x;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_value();
		int r;
		int nbytes;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		if (r < 60) nbytes = 1;
		else if (r < 85) nbytes = 2;
		else if (r < 95) nbytes = $urandom_range(3, 5);
		else nbytes = $urandom_range(6, 11);
		for (int i = 0; i < nbytes; i++) begin
			b = 8'($urandom_range(0, 127));
			if (i < nbytes - 1)
				b[7] = 1'b1;
			send_item(mk_byte(b));
			useful++;
		end
	endtask

	task automatic random_stream();
		int kind;
		int nvals;
		int r;
		logic [31:0] tot;
		kind = $urandom_range(0, 99);
		if (kind < 40) tot = $urandom_range(1, 200);
		else if (kind < 75) tot = $urandom_range(201, 100000);
		else if (kind < 97) tot = $urandom;
		else tot = 32'd0;
		send_item(mk(ulebrd_pkg::CMD_START, tot, 8'($urandom)));
		useful++;
		nvals = $urandom_range(0, 24);
		repeat (nvals) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				send_item(mk(CMD_UNUSED, $urandom, 8'($urandom)));
			end else if (r < 8) begin
				send_item(mk_byte(8'($urandom)));
				useful++;
			end else begin
				send_value();
			end
		end
		if ($urandom_range(0, 99) < 88) begin
			send_item(mk(ulebrd_pkg::CMD_END, $urandom, 8'($urandom)));
			useful++;
		end
		if ($urandom_range(0, 99) < 10)
			repeat ($urandom_range(1, 3)) send_item(mk_byte(8'($urandom)));
	endtask

	task automatic directed_items();
		// nothing opened since reset
		send_item(mk_byte(8'h05));
		send_item(mk(ulebrd_pkg::CMD_END, $urandom, 8'($urandom)));
		send_item(mk(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF));
		// single-symbol stream, later bytes dropped once full
		send_item(mk(ulebrd_pkg::CMD_START, 32'd1, 8'hFF));
		send_item(mk_byte(8'h00));
		send_item(mk_byte(8'h2A));
		send_item(mk(ulebrd_pkg::CMD_END, $urandom, 8'($urandom)));
		// maximum total, all-ones value past 64 bits, clipped to what is left
		send_item(mk(ulebrd_pkg::CMD_START, 32'hFFFF_FFFF, 8'h00));
		send_item(mk_byte(8'h7F));
		repeat (10) send_item(mk_byte(8'hFF));
		send_item(mk_byte(8'h7F));
		send_item(mk(ulebrd_pkg::CMD_END, 32'h0000_0000, 8'h00));
		// two-byte value, unfinished value dropped, padding run on end
		send_item(mk(ulebrd_pkg::CMD_START, 32'd1000, 8'h00));
		send_item(mk_byte(8'h80));
		send_item(mk_byte(8'h01));
		send_item(mk_byte(8'h80));
		send_item(mk(ulebrd_pkg::CMD_END, $urandom, 8'($urandom)));
		// zero total is full at once
		send_item(mk(ulebrd_pkg::CMD_START, 32'd0, 8'h00));
		send_item(mk_byte(8'h01));
		send_item(mk(ulebrd_pkg::CMD_END, $urandom, 8'($urandom)));
	endtask

	initial begin
		int phase;
		sb = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_items();
		drain();
		phase = 0;
		while (useful < USEFUL_ITEMS) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			if (phase == 2) begin
				tx_calm = 1'b1;
				hold_req = 300;
			end
			repeat (10) random_stream();
			drain();
			phase++;
		end
		drain();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
